>>> hdl/ps2mc_pkg.sv
// Shared types, constants and register codes for the PS/2 mouse cursor block.
`timescale 1ns / 1ps

package ps2mc_pkg;

  // Cursor coordinate width inside the block
  localparam int COORD_BITS  = 12;
  // Fixed field widths
  localparam int BYTE_BITS   = 8;
  localparam int POS_BITS    = 12;
  localparam int SCREEN_BITS = 12;
  localparam int SIZE_BITS   = 8;
  localparam int DELTA_BITS  = 9;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  // Working width of the signed add and clamp
  localparam int SUM_W = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 2;
  localparam int COORD_MAX_INT = (1 << COORD_BITS) - 1;
  localparam logic signed [SUM_W-1:0] COORD_MAX_S = SUM_W'(COORD_MAX_INT);

  // Header byte bit positions
  localparam int HDR_LEFT_BIT   = 0;
  localparam int HDR_RIGHT_BIT  = 1;
  localparam int HDR_MIDDLE_BIT = 2;
  localparam int HDR_SYNC_BIT   = 3;
  localparam int HDR_XSIGN_BIT  = 4;
  localparam int HDR_YSIGN_BIT  = 5;

  // Register reset values
  localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST = SCREEN_BITS'(1024);
  localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST = SCREEN_BITS'(768);
  localparam logic [SIZE_BITS-1:0]   CURSOR_W_RST = SIZE_BITS'(16);
  localparam logic [SIZE_BITS-1:0]   CURSOR_H_RST = SIZE_BITS'(16);
  localparam int START_X_RST = 512;
  localparam int START_Y_RST = 384;

  // Cursor position after reset, saturated to the coordinate range
  localparam logic [COORD_BITS-1:0] CUR_X_RST =
    COORD_BITS'((START_X_RST > COORD_MAX_INT) ? COORD_MAX_INT : START_X_RST);
  localparam logic [COORD_BITS-1:0] CUR_Y_RST =
    COORD_BITS'((START_Y_RST > COORD_MAX_INT) ? COORD_MAX_INT : START_Y_RST);

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCREEN_W = 3'd0,
    CFG_SCREEN_H = 3'd1,
    CFG_CURSOR_W = 3'd2,
    CFG_CURSOR_H = 3'd3,
    CFG_START_X  = 3'd4,
    CFG_START_Y  = 3'd5
  } cfg_idx_e;

  // Packet byte phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_XDATA = 2'd1,
    PH_YDATA = 2'd2
  } phase_e;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen_w;
    logic [SCREEN_BITS-1:0] screen_h;
    logic [SIZE_BITS-1:0]   cursor_w;
    logic [SIZE_BITS-1:0]   cursor_h;
  } cfg_t;

endpackage

>>> hdl/ps2mc_if.sv
// Stream interfaces for mouse bytes, cursor results and register writes.
`timescale 1ns / 1ps

interface ps2mc_byte_if import ps2mc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] packet_byte;

  modport source (output valid, output packet_byte, input ready);
  modport sink   (input valid, input packet_byte, output ready);
endinterface

interface ps2mc_pos_if import ps2mc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] pos_x;
  logic [POS_BITS-1:0] pos_y;
  logic                left_button;
  logic                middle_button;
  logic                right_button;

  modport source (output valid, output pos_x, output pos_y, output left_button,
                  output middle_button, output right_button, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input left_button,
                  input middle_button, input right_button, output ready);
endinterface

interface ps2mc_cfg_if import ps2mc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/ps2mc_cfg_regs.sv
// Configuration register file for screen and pointer sizes.
`timescale 1ns / 1ps

module ps2mc_cfg_regs import ps2mc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  ps2mc_cfg_if.sink      cfg_i,
  output cfg_t           cfg_o
);

  logic [SCREEN_BITS-1:0] screen_w_q, screen_h_q;
  logic [SIZE_BITS-1:0]   cursor_w_q, cursor_h_q;
  logic                   wr;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  // Register writes; the start position only acts through reset, which
  // restores its default, so start writes are decoded and dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= SCREEN_W_RST;
      screen_h_q <= SCREEN_H_RST;
      cursor_w_q <= CURSOR_W_RST;
      cursor_h_q <= CURSOR_H_RST;
    end else if (wr) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_SCREEN_W: screen_w_q <= cfg_i.data[SCREEN_BITS-1:0];
        CFG_SCREEN_H: screen_h_q <= cfg_i.data[SCREEN_BITS-1:0];
        CFG_CURSOR_W: cursor_w_q <= cfg_i.data[SIZE_BITS-1:0];
        CFG_CURSOR_H: cursor_h_q <= cfg_i.data[SIZE_BITS-1:0];
        CFG_START_X, CFG_START_Y: ;
        default: ;
      endcase
    end
  end

  assign cfg_o.screen_w = screen_w_q;
  assign cfg_o.screen_h = screen_h_q;
  assign cfg_o.cursor_w = cursor_w_q;
  assign cfg_o.cursor_h = cursor_h_q;

endmodule

>>> hdl/ps2mc_axis_step.sv
// One axis: apply a signed 9-bit delta and clamp to the visible range.
`timescale 1ns / 1ps

module ps2mc_axis_step import ps2mc_pkg::*; (
  input  logic [COORD_BITS-1:0]  cur_i,
  input  logic [DELTA_BITS-1:0]  delta_i,
  input  logic                   sub_i,
  input  logic [SCREEN_BITS-1:0] screen_i,
  input  logic [SIZE_BITS-1:0]   size_i,
  output logic [COORD_BITS-1:0]  pos_o
);

  logic signed [SUM_W-1:0] cur_ext, d_ext, sum, hi, lim_hi, lim_max, lim_lo;

  // Sign and zero extension to the working width
  assign cur_ext = signed'({{(SUM_W-COORD_BITS){1'b0}}, cur_i});
  assign d_ext   = signed'({{(SUM_W-DELTA_BITS){delta_i[DELTA_BITS-1]}}, delta_i});
  assign hi      = signed'({{(SUM_W-SCREEN_BITS){1'b0}}, screen_i})
                 - signed'({{(SUM_W-SIZE_BITS){1'b0}}, size_i});

  // Y moves the other way, screen rows grow downward
  assign sum = sub_i ? (cur_ext - d_ext) : (cur_ext + d_ext);

  // Upper bound first, then coordinate range, then zero; a pointer wider
  // than the screen leaves a negative bound and ends at zero
  always_comb begin
    lim_hi  = (sum >= hi) ? hi : sum;
    lim_max = (lim_hi > COORD_MAX_S) ? COORD_MAX_S : lim_hi;
    lim_lo  = (lim_max <= 0) ? '0 : lim_max;
  end

  assign pos_o = lim_lo[COORD_BITS-1:0];

endmodule

>>> hdl/ps2_mouse_packet_cursor.sv
// Flow: an accepted byte enters the input byte register, and a packet's third byte then loads the result.
// Throughput: one byte per cycle; the third byte of a packet waits only
// while the result register holds an untaken result.
// Stages: input byte register, then phase logic and add-and-clamp into the result register.
// Reset: asynchronous, active low; packet phase idle, cursor at the default
// start position, registers at their defaults, no result pending.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor import ps2mc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ps2mc_byte_if.sink   byte_i,
  ps2mc_pos_if.source  pos_o,
  ps2mc_cfg_if.sink    cfg_i
);

  cfg_t                  cfg;
  logic                  in_valid_q;
  logic [BYTE_BITS-1:0]  in_byte_q;
  phase_e                phase_q, phase_d;
  logic [BYTE_BITS-1:0]  header_q, xbyte_q;
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q, new_x, new_y;
  logic                  out_valid_q;
  logic [POS_BITS-1:0]   pos_x_q, pos_y_q;
  logic                  left_q, middle_q, right_q;
  logic                  out_free, adv, hdr_load, x_load, res_load;
  logic [DELTA_BITS-1:0] dx, dy;

  ps2mc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake: the input stage moves on unless it holds a packet end and
  // the result register is still occupied
  assign out_free     = ~out_valid_q | pos_o.ready;
  assign adv          = in_valid_q & ((phase_q != PH_YDATA) | out_free);
  assign byte_i.ready = ~in_valid_q | adv;

  // Input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.packet_byte;
    end
  end

  // Phase next state
  always_comb begin
    phase_d = phase_q;
    if (adv) begin
      case (phase_q)
        PH_XDATA: phase_d = PH_YDATA;
        PH_YDATA: phase_d = PH_IDLE;
        default:  phase_d = in_byte_q[HDR_SYNC_BIT] ? PH_XDATA : PH_IDLE;
      endcase
    end
  end

  // Phase outputs
  always_comb begin
    hdr_load = 1'b0;
    x_load   = 1'b0;
    res_load = 1'b0;
    case (phase_q)
      PH_XDATA: x_load   = adv;
      PH_YDATA: res_load = adv;
      default:  hdr_load = adv & in_byte_q[HDR_SYNC_BIT];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Header and X data bytes; read only after a load
  always_ff @(posedge clk_i) begin
    if (hdr_load) header_q <= in_byte_q;
    if (x_load)   xbyte_q  <= in_byte_q;
  end

  // 9-bit deltas: header sign bit over the data byte
  assign dx = {header_q[HDR_XSIGN_BIT], xbyte_q};
  assign dy = {header_q[HDR_YSIGN_BIT], in_byte_q};

  ps2mc_axis_step u_x (
    .cur_i    (cur_x_q),
    .delta_i  (dx),
    .sub_i    (1'b0),
    .screen_i (cfg.screen_w),
    .size_i   (cfg.cursor_w),
    .pos_o    (new_x)
  );

  ps2mc_axis_step u_y (
    .cur_i    (cur_y_q),
    .delta_i  (dy),
    .sub_i    (1'b1),
    .screen_i (cfg.screen_h),
    .size_i   (cfg.cursor_h),
    .pos_o    (new_y)
  );

  // Cursor position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= CUR_X_RST;
      cur_y_q <= CUR_Y_RST;
    end else if (res_load) begin
      cur_x_q <= new_x;
      cur_y_q <= new_y;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (pos_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      pos_x_q  <= POS_BITS'(new_x);
      pos_y_q  <= POS_BITS'(new_y);
      left_q   <= header_q[HDR_LEFT_BIT];
      middle_q <= header_q[HDR_MIDDLE_BIT];
      right_q  <= header_q[HDR_RIGHT_BIT];
    end
  end

  assign pos_o.valid         = out_valid_q;
  assign pos_o.pos_x         = pos_x_q;
  assign pos_o.pos_y         = pos_y_q;
  assign pos_o.left_button   = left_q;
  assign pos_o.middle_button = middle_q;
  assign pos_o.right_button  = right_q;

`ifndef SYNTHESIS
  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pos_o.ready) |-> !res_load)
    else $error("result register overwritten while pending");

  // A new result only follows the third byte of a packet
  a_rose_from_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && (phase_q == PH_YDATA)))
    else $error("result without a completed packet");

  // An idle byte without the sync bit is dropped
  a_drop_unsynced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (phase_q == PH_IDLE) && !in_byte_q[HDR_SYNC_BIT]) |=> (phase_q == PH_IDLE))
    else $error("unsynced byte started a packet");

  // The input stage only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |-> (out_valid_q && !pos_o.ready && (phase_q == PH_YDATA)))
    else $error("input stage stalled without cause");
`endif

endmodule

>>> bench/ps2_mouse_packet_cursor_tb.sv
// Self-checking bench for the PS/2 mouse packet decoder: directed packets, then random traffic.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tb;
  import ps2mc_pkg::*;

  // Run limits
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_PCT     = 23;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_7 = 3'd7;

  // Direction bias for random packets
  typedef enum int {DRIFT_ANY, DRIFT_POS, DRIFT_NEG} drift_e;

  // One expected cursor update
  typedef struct packed {
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
    logic                left;
    logic                middle;
    logic                right;
  } cursor_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ps2mc_byte_if byte_bus ();
  ps2mc_pos_if  pos_bus ();
  ps2mc_cfg_if  cfg_bus ();

  ps2_mouse_packet_cursor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_bus),
    .pos_o  (pos_bus),
    .cfg_i  (cfg_bus)
  );

  // Clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the decoder state and its registers
  phase_e                 trk_phase  = PH_IDLE;
  logic [BYTE_BITS-1:0]   trk_header = '0;
  logic [BYTE_BITS-1:0]   trk_xbyte  = '0;
  int                     trk_x      = int'(CUR_X_RST);
  int                     trk_y      = int'(CUR_Y_RST);
  logic [SCREEN_BITS-1:0] reg_screen_w = SCREEN_W_RST;
  logic [SCREEN_BITS-1:0] reg_screen_h = SCREEN_H_RST;
  logic [SIZE_BITS-1:0]   reg_cursor_w = CURSOR_W_RST;
  logic [SIZE_BITS-1:0]   reg_cursor_h = CURSOR_H_RST;
  logic [POS_BITS-1:0]    reg_start_x  = POS_BITS'(START_X_RST);
  logic [POS_BITS-1:0]    reg_start_y  = POS_BITS'(START_Y_RST);

  cursor_t cursor_q[$];

  bit no_idle       = 1'b0;
  int mismatches    = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int reg_writes    = 0;
  int settings_used = 0;
  int cycle_count   = 0;

  // Upper limit first, then the coordinate range, then zero
  function automatic int clamp_coord(int p, int scr, int sz);
    int hi;
    hi = scr - sz;
    if (p >= hi) p = hi;
    if (p > COORD_MAX_INT) p = COORD_MAX_INT;
    if (p <= 0) p = 0;
    return p;
  endfunction

  // Advance the shadow decoder by one accepted byte
  function automatic void track_byte(logic [BYTE_BITS-1:0] b);
    int      dx;
    int      dy;
    cursor_t upd;
    case (trk_phase)
      PH_XDATA: begin
        trk_xbyte = b;
        trk_phase = PH_YDATA;
      end
      PH_YDATA: begin
        trk_phase = PH_IDLE;
        dx = trk_header[HDR_XSIGN_BIT] ? int'(trk_xbyte) - 256 : int'(trk_xbyte);
        dy = trk_header[HDR_YSIGN_BIT] ? int'(b) - 256 : int'(b);
        trk_x = clamp_coord(trk_x + dx, int'(reg_screen_w), int'(reg_cursor_w));
        trk_y = clamp_coord(trk_y - dy, int'(reg_screen_h), int'(reg_cursor_h));
        upd.x      = POS_BITS'(trk_x);
        upd.y      = POS_BITS'(trk_y);
        upd.left   = trk_header[HDR_LEFT_BIT];
        upd.middle = trk_header[HDR_MIDDLE_BIT];
        upd.right  = trk_header[HDR_RIGHT_BIT];
        cursor_q.push_back(upd);
      end
      default: begin
        // only a byte with the sync bit opens a packet
        if (b[HDR_SYNC_BIT]) begin
          trk_header = b;
          trk_phase  = PH_XDATA;
        end else begin
          trk_phase = PH_IDLE;
        end
      end
    endcase
  endfunction

  // One byte transfer, with random idle cycles ahead of it
  task automatic send_byte(logic [BYTE_BITS-1:0] b);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_bus.valid       <= 1'b1;
    byte_bus.packet_byte <= b;
    do @(posedge clk_i); while (!byte_bus.ready);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_packet(logic [7:0] hdr, logic [7:0] xb, logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  // Stop sending and let every pending result and in-flight byte drain
  task automatic settle();
    @(negedge clk_i);
    byte_bus.valid <= 1'b0;
    while (cursor_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write transfer
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_SCREEN_W: reg_screen_w = val;
      CFG_SCREEN_H: reg_screen_h = val;
      CFG_CURSOR_W: reg_cursor_w = val[SIZE_BITS-1:0];
      CFG_CURSOR_H: reg_cursor_h = val[SIZE_BITS-1:0];
      CFG_START_X:  reg_start_x  = val;
      CFG_START_Y:  reg_start_y  = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Full register set, written once the block is quiet
  task automatic apply_setting(int sw, int sh, int cw, int ch);
    settle();
    write_reg(CFG_SCREEN_W, CFG_DATA_BITS'(sw));
    write_reg(CFG_SCREEN_H, CFG_DATA_BITS'(sh));
    write_reg(CFG_CURSOR_W, CFG_DATA_BITS'(cw));
    write_reg(CFG_CURSOR_H, CFG_DATA_BITS'(ch));
    // start position only takes effect at reset, so the cursor must not jump
    write_reg(CFG_START_X, CFG_DATA_BITS'($urandom_range(4095)));
    write_reg(CFG_START_Y, CFG_DATA_BITS'($urandom_range(4095)));
    settings_used++;
  endtask

  // Mostly well-formed packets, some stray bytes that break alignment
  task automatic run_traffic(int n_bytes, drift_e drift);
    int sent;
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(99) < 12) begin
        send_byte(8'($urandom_range(255)));
        sent += 1;
      end else begin
        hdr = 8'($urandom_range(255));
        hdr[HDR_SYNC_BIT] = 1'b1;
        xb  = 8'($urandom_range(255));
        yb  = 8'($urandom_range(255));
        case (drift)
          DRIFT_POS: begin
            hdr[HDR_XSIGN_BIT] = 1'b0;
            hdr[HDR_YSIGN_BIT] = 1'b0;
            xb = 8'($urandom_range(255, 128));
            yb = 8'($urandom_range(255, 128));
          end
          DRIFT_NEG: begin
            hdr[HDR_XSIGN_BIT] = 1'b1;
            hdr[HDR_YSIGN_BIT] = 1'b1;
            xb = 8'($urandom_range(127));
            yb = 8'($urandom_range(127));
          end
          default: ;
        endcase
        send_packet(hdr, xb, yb);
        sent += 3;
      end
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random back-pressure
  always @(negedge clk_i) begin
    pos_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    cursor_t want;
    if (rst_ni && pos_bus.valid && pos_bus.ready) begin
      results_seen++;
      if (cursor_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual x=%0d y=%0d",
                 $time, pos_bus.pos_x, pos_bus.pos_y);
        mismatches++;
      end else begin
        want = cursor_q.pop_front();
        check_field("pos_x", want.x, pos_bus.pos_x);
        check_field("pos_y", want.y, pos_bus.pos_y);
        check_field("left_button", want.left, pos_bus.left_button);
        check_field("middle_button", want.middle, pos_bus.middle_button);
        check_field("right_button", want.right, pos_bus.right_button);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Bytes without the sync bit are dropped while idle
  task automatic test_sync_and_drop();
    send_byte(8'h00);
    send_byte(8'hF7);
    send_byte(8'h07);
    // data bytes may carry any bit pattern, sync bit clear here
    send_packet(8'h08, 8'h00, 8'h00);
  endtask

  task automatic test_buttons();
    send_packet(8'h0D, 8'h05, 8'h03);
    send_packet(8'h0A, 8'h08, 8'hF8);
  endtask

  // Largest moves both ways, overflow bits set
  task automatic test_delta_extremes();
    send_packet(8'h08, 8'hFF, 8'hFF);
    send_packet(8'h38, 8'h00, 8'h00);
    send_packet(8'hFF, 8'h80, 8'h7F);
  endtask

  // Pointer wider than the screen pins x at zero; spare indexes are ignored
  task automatic test_oversized_cursor();
    apply_setting(10, 1, 255, 0);
    write_reg(CFG_SPARE_6, 12'hFFF);
    write_reg(CFG_SPARE_7, 12'h000);
    send_packet(8'h08, 8'h7F, 8'h81);
  endtask

  task automatic test_random_settings();
    // reset values, free movement
    apply_setting(1024, 768, 16, 16);
    run_traffic(300, DRIFT_ANY);
    // widest screen, no pointer: drive into the left, right, top and bottom borders
    apply_setting(4095, 4095, 0, 0);
    run_traffic(300, DRIFT_POS);
    run_traffic(300, DRIFT_NEG);
    // smallest screen, positions only 0 or 1
    apply_setting(1, 1, 0, 0);
    run_traffic(150, DRIFT_ANY);
    // pointer larger than the screen, upper data bits of the size masked off
    apply_setting(200, 100, 12'hFFF, 12'hAFF);
    run_traffic(150, DRIFT_ANY);
    repeat (3) begin
      apply_setting($urandom_range(4095, 1), $urandom_range(4095, 1),
                    $urandom_range(4095), $urandom_range(4095));
      write_reg(CFG_SPARE_6, CFG_DATA_BITS'($urandom_range(4095)));
      run_traffic(150, drift_e'($urandom_range(2)));
    end
  endtask

  task automatic test_no_idle_stretch();
    apply_setting($urandom_range(4095, 256), $urandom_range(4095, 256),
                  $urandom_range(255), $urandom_range(255));
    no_idle = 1'b1;
    run_traffic(300, DRIFT_ANY);
    no_idle = 1'b0;
  endtask

  initial begin
    byte_bus.valid       = 1'b0;
    byte_bus.packet_byte = '0;
    pos_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_SCREEN_W;
    cfg_bus.data         = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_sync_and_drop();
    test_buttons();
    test_delta_extremes();
    test_oversized_cursor();
    test_random_settings();
    test_no_idle_stretch();
    settle();

    $display("Sent %0d mouse bytes, checked %0d cursor results.", bytes_sent, results_seen);
    $display("Made %0d register writes across %0d screen and pointer settings.",
             reg_writes, settings_used);
    if (mismatches == 0 && cursor_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
